/* rtl/in_order_load_store_queue_unit_macros.svh */
// assertion macros used by the load/store queue checker
`ifndef IN_ORDER_LOAD_STORE_QUEUE_UNIT_MACROS_SVH
`define IN_ORDER_LOAD_STORE_QUEUE_UNIT_MACROS_SVH

// property holds on every edge outside reset
`define LSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition on one edge forces an outcome on the next edge
`define LSQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/lsq_pkg.sv */
// shared types and constants for the in-order load/store queue
package lsq_pkg;

   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned ENTRY_W     = 3;
   localparam int unsigned CMP_W       = (PTR_W > ENTRY_W) ? PTR_W : ENTRY_W;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   // one command word as captured from the request ports
   typedef struct packed {
      logic      allocate_request;
      logic      complete_valid;
      entry_type complete_entry;
      entry_type probe_entry;
      logic      flush_request;
   } req_type;

   // one response word
   typedef struct packed {
      entry_type allocated_entry;
      logic      allocate_rejected;
      logic      queue_full;
      logic      probe_at_head;
      logic      retired;
      logic      flushing;
   } rsp_type;

endpackage

/* rtl/in_order_load_store_queue_unit.sv */
// top level of the in-order load/store queue
//
// one command word is one processor tick: allocate request, completion mark,
// head probe and flush request. a word is taken at a rising edge with start
// high and busy low; busy is high only while reset is held, so a new word
// can be issued in every cycle (one word per cycle sustained).
// the word lands in the input register; from there it updates the ring state
// and loads the response register, and the response shows on the rsp_ ports
// with rsp_valid high for exactly one cycle.
// responses come in issue order, one per word, and cannot be held off.
// ring state (head/tail, busy/ready bits, pending flush) is read as it was
// before the word and written at the end of it. a flush request arms a full
// clear that the following word performs; that word does nothing else.
// synchronous reset empties the ring, clears the pending flush and drops any
// word in flight; no clearing pass is needed afterwards.
module in_order_load_store_queue_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_allocate_request,
   input  logic               req_complete_valid,
   input  lsq_pkg::entry_type req_complete_entry,
   input  lsq_pkg::entry_type req_probe_entry,
   input  logic               req_flush_request,
   output logic               rsp_valid,
   output lsq_pkg::entry_type rsp_allocated_entry,
   output logic               rsp_allocate_rejected,
   output logic               rsp_queue_full,
   output logic               rsp_probe_at_head,
   output logic               rsp_retired,
   output logic               rsp_flushing
);
   import lsq_pkg::*;

   logic    accept;
   req_type req_word;
   logic    stage_valid;
   req_type stage_word;
   rsp_type ring_rsp;
   rsp_type out_word;

   // only reset holds the command port off
   assign busy   = reset;
   assign accept = start && !busy;

   assign req_word.allocate_request = req_allocate_request;
   assign req_word.complete_valid   = req_complete_valid;
   assign req_word.complete_entry   = req_complete_entry;
   assign req_word.probe_entry      = req_probe_entry;
   assign req_word.flush_request    = req_flush_request;

   // capture the command word
   lsq_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_in    (req_word),
      .req_valid (stage_valid),
      .req_out   (stage_word)
   );

   // ring state and its per-word update
   lsq_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .req_valid (stage_valid),
      .req       (stage_word),
      .rsp       (ring_rsp)
   );

   // register the response word and strobe it out
   lsq_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .rsp_valid_in (stage_valid),
      .rsp_in       (ring_rsp),
      .rsp_valid    (rsp_valid),
      .rsp_out      (out_word)
   );

   assign rsp_allocated_entry   = out_word.allocated_entry;
   assign rsp_allocate_rejected = out_word.allocate_rejected;
   assign rsp_queue_full        = out_word.queue_full;
   assign rsp_probe_at_head     = out_word.probe_at_head;
   assign rsp_retired           = out_word.retired;
   assign rsp_flushing          = out_word.flushing;

endmodule

/* rtl/lsq_in_reg.sv */
// input register that captures one command word per accepted cycle
module lsq_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lsq_pkg::req_type req_in,
   output logic             req_valid,
   output lsq_pkg::req_type req_out
);
   import lsq_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   req_type req_ff_in;

   assign valid_in  = accept;
   assign req_ff_in = accept ? req_in : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_ff_in;
   end

   assign req_valid = valid_ff;
   assign req_out   = req_ff;

endmodule

/* rtl/lsq_ring.sv */
// ring state: busy/ready bits, head/tail pointers, flush flag and per-word update
module lsq_ring (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  lsq_pkg::req_type req,
   output lsq_pkg::rsp_type rsp
);
   import lsq_pkg::*;

   logic [QUEUE_DEPTH-1:0] busy_ff, busy_in;
   logic [QUEUE_DEPTH-1:0] ready_ff, ready_in;
   ptr_type                head_ff, head_in;
   ptr_type                tail_ff, tail_in;
   logic                   flush_pending_ff, flush_pending_in;

   logic [CMP_W-1:0] probe_x;
   logic [CMP_W-1:0] head_x;
   logic [CMP_W-1:0] comp_x;
   logic             comp_in_range;
   logic             full;
   logic             do_alloc;
   logic             do_retire;

   function automatic ptr_type next_slot(ptr_type p);
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr_type'(p + ptr_type'(1));
   endfunction

   assign probe_x       = CMP_W'(req.probe_entry);
   assign head_x        = CMP_W'(head_ff);
   assign comp_x        = CMP_W'(req.complete_entry);
   assign comp_in_range = ({1'b0, comp_x} < (CMP_W + 1)'(QUEUE_DEPTH));
   assign full          = busy_ff[tail_ff];
   assign do_alloc      = req.allocate_request && !full;
   assign do_retire     = busy_ff[head_ff] && ready_ff[head_ff];

   always_comb begin
      busy_in          = busy_ff;
      ready_in         = ready_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      flush_pending_in = flush_pending_ff;

      rsp.allocated_entry   = '0;
      rsp.allocate_rejected = 1'b0;
      rsp.queue_full        = full;
      rsp.probe_at_head     = (probe_x == head_x);
      rsp.retired           = 1'b0;
      rsp.flushing          = 1'b0;

      if (req_valid) begin
         if (flush_pending_ff) begin
            // flush tick: everything else is dropped
            busy_in               = '0;
            ready_in              = '0;
            head_in               = '0;
            tail_in               = '0;
            flush_pending_in      = 1'b0;
            rsp.flushing          = 1'b1;
            rsp.allocate_rejected = req.allocate_request;
         end else begin
            rsp.allocate_rejected = req.allocate_request && full;
            if (req.complete_valid && comp_in_range) begin
               ready_in[comp_x[PTR_W-1:0]] = 1'b1;
            end
            // retire overrides a completion of the same entry
            if (do_retire) begin
               busy_in[head_ff]  = 1'b0;
               ready_in[head_ff] = 1'b0;
               head_in           = next_slot(head_ff);
               rsp.retired       = 1'b1;
            end
            // allocation overrides both
            if (do_alloc) begin
               busy_in[tail_ff]    = 1'b1;
               ready_in[tail_ff]   = 1'b0;
               tail_in             = next_slot(tail_ff);
               rsp.allocated_entry = entry_type'(tail_ff);
            end
            flush_pending_in = req.flush_request;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= '0;
         ready_ff         <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         flush_pending_ff <= 1'b0;
      end else begin
         busy_ff          <= busy_in;
         ready_ff         <= ready_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         flush_pending_ff <= flush_pending_in;
      end
   end

endmodule

/* rtl/lsq_out_reg.sv */
// response register with a one-cycle strobe
module lsq_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_valid_in,
   input  lsq_pkg::rsp_type rsp_in,
   output logic             rsp_valid,
   output lsq_pkg::rsp_type rsp_out
);
   import lsq_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_ff_in;

   assign rsp_ff_in = rsp_valid_in ? rsp_in : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_ff_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

/* rtl/lsq_checker.sv */
// port-level checks for the load/store queue, bound to the top level
`include "in_order_load_store_queue_unit_macros.svh"

module lsq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input lsq_pkg::entry_type rsp_allocated_entry,
   input logic               rsp_allocate_rejected,
   input logic               rsp_queue_full,
   input logic               rsp_retired,
   input logic               rsp_flushing
);

   logic accept_seen;
   logic flush_seen;
   logic flush_idle;
   logic reject_seen;

   assign accept_seen = start && !busy;
   assign flush_seen  = rsp_valid && rsp_flushing;
   assign flush_idle  = !rsp_retired && (rsp_allocated_entry == '0);
   assign reject_seen = rsp_valid && rsp_allocate_rejected && !rsp_flushing;

   // a response for every accepted word, through the input and response registers
   `LSQ_ASSERT_NEXT(a_rsp_follows, clock, reset, $past(accept_seen), rsp_valid, "word lost")

   // no response without an accepted word
   `LSQ_ASSERT(a_no_extra_rsp, clock, reset, !rsp_valid || $past(accept_seen, 2), "extra word")

   // a flush tick does nothing else
   `LSQ_ASSERT(a_flush_quiet, clock, reset, !flush_seen || flush_idle, "flush tick did work")

   // refusal outside a flush means the ring was full
   `LSQ_ASSERT(a_reject_full, clock, reset, !reject_seen || rsp_queue_full, "refused when not full")

   // a flush is never performed twice in a row
   `LSQ_ASSERT_NEXT(a_flush_once, clock, reset, flush_seen, !flush_seen, "double flush")

endmodule

bind in_order_load_store_queue_unit lsq_checker u_lsq_checker (.*);
